/* rtl/core/assert_macros.svh */
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is high
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// next-cycle implication that also holds across reset
`define ASSERT_NXT_NR(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication across reset");

`endif

/* rtl/core/epi_pkg.sv */
// ----------------------------------------------------------------------------
// epi_pkg
// Shared types, constants and the quarter-sine table of the pose interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package epi_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int SINE_DEPTH = 256;
   localparam int SINE_BITS  = $clog2(SINE_DEPTH);
   localparam int FRAME_BITS = 16;
   localparam int NVAL       = 7;
   localparam int IDX_W      = $clog2(NVAL);
   localparam int VAL_W      = 32;
   localparam int WGT_W      = FRAC_BITS + 1;
   localparam int PROG_W     = FRAC_BITS + 2;
   localparam int DIFF_W     = VAL_W + 1;
   localparam int PROD_W     = DIFF_W + WGT_W + 1;
   localparam int IDX_SHIFT  = FRAC_BITS - SINE_BITS;

   localparam logic [WGT_W-1:0]  ONE_FIX  = WGT_W'(1) << FRAC_BITS;
   localparam logic [PROG_W-1:0] HALF_FIX = PROG_W'(1) << (FRAC_BITS - 1);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

   localparam logic [2:0] MODE_LINEAR    = 3'd0;
   localparam logic [2:0] MODE_LIN_SINE  = 3'd1;
   localparam logic [2:0] MODE_SINE      = 3'd2;
   localparam logic [2:0] MODE_SINE_SQSW = 3'd3;
   localparam logic [2:0] MODE_SINE_SQ   = 3'd4;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_SET   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [2:0]            ease_mode;
      logic [FRAME_BITS-1:0] frames;
      logic [2:0]            group_mask;
      logic signed [31:0]    pos_x;
      logic signed [31:0]    pos_y;
      logic signed [31:0]    pos_z;
      logic signed [31:0]    rot_x;
      logic signed [31:0]    rot_y;
      logic signed [31:0]    rot_z;
      logic signed [31:0]    zoom_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_rot_x;
      logic signed [31:0] out_rot_y;
      logic signed [31:0] out_rot_z;
      logic signed [31:0] out_zoom;
      logic               busy_res;
   } rsp_type;

   typedef logic [WGT_W-1:0] sine_tab_type [0:SINE_DEPTH];

   // sin(90 deg * i / depth) from a Q30 Taylor series, rounded half up
   function automatic sine_tab_type build_sine();
      sine_tab_type       tab;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      for (int i = 0; i <= SINE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (64'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         if (r > 64'(ONE_FIX)) begin
            r = 64'(ONE_FIX);
         end
         tab[i] = WGT_W'(r);
      end
      tab[0]          = '0;
      tab[SINE_DEPTH] = ONE_FIX;
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

endpackage

`default_nettype wire

/* rtl/core/epi_recip.sv */
// ----------------------------------------------------------------------------
// epi_recip
// Restoring divider, one quotient bit per cycle: floor(2^FRAC_BITS / frames).
// ----------------------------------------------------------------------------
`default_nettype none

module epi_recip (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start_i,
   input  wire logic [epi_pkg::FRAME_BITS-1:0] divisor_i,
   output logic                               done_o,
   output logic [epi_pkg::WGT_W-1:0]          quot_o
);
   import epi_pkg::*;

   localparam int Q_BITS = WGT_W;
   localparam int CNT_W  = $clog2(Q_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [FRAME_BITS-1:0] div_ff, div_in;
   logic [FRAME_BITS-1:0] rem_ff, rem_in;
   logic [Q_BITS-1:0]     num_ff, num_in;
   logic [Q_BITS-1:0]     quo_ff, quo_in;
   logic [FRAME_BITS:0]   trial;
   logic                  fits;

   assign trial = {rem_ff, num_ff[Q_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start_i) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(Q_BITS);
         div_in  = divisor_i;
         rem_in  = '0;
         num_in  = ONE_FIX;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? FRAME_BITS'(trial - {1'b0, div_ff}) : FRAME_BITS'(trial);
         num_in = {num_ff[Q_BITS-2:0], 1'b0};
         quo_in = {quo_ff[Q_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done_o = done_ff;
   assign quot_o = quo_ff;

endmodule

`default_nettype wire

/* rtl/core/epi_mul.sv */
// ----------------------------------------------------------------------------
// epi_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module epi_mul (
   input  wire logic                               clock,
   input  wire logic signed [epi_pkg::DIFF_W-1:0]  a_i,
   input  wire logic        [epi_pkg::WGT_W-1:0]   b_i,
   output logic signed      [epi_pkg::PROD_W-1:0]  prod_o
);
   import epi_pkg::*;

   logic signed [WGT_W:0]    b_s;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign b_s     = {1'b0, b_i};
   assign prod_in = a_i * b_s;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_o = prod_ff;

endmodule

`default_nettype wire

/* rtl/core/eased_pose_interpolator.sv */
// ----------------------------------------------------------------------------
// eased_pose_interpolator
// Moves seven Q16.16 pose values (position xyz, rotation xyz, zoom) toward
// targets over a number of ticks with linear, sine, sine-squared or switching
// easing. Every transaction on req gives exactly one transaction on rsp with
// the current values and the busy flag. One item is handled at a time and
// req_stall stays high while it is worked on. A set or an idle tick goes
// straight to the done state and the result register; a start runs the
// one-bit-per-cycle restoring divider for 1/frames, and an active tick runs
// a multiply and an add state for each value in turn, after a squaring of the
// weight in sine-squared mode, on the single multiplier shared by the seven
// interpolations; the last tick of a transition snaps to the targets. A
// finished result waits in the output register while rsp_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_pose_interpolator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire epi_pkg::req_type req,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output epi_pkg::rsp_type      rsp
);
   import epi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQ,
      ST_SQW,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   localparam logic [1:0] GROUP_OF [NVAL] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2};

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [VAL_W-1:0]      current_ff [NVAL];
   logic [VAL_W-1:0]      current_in [NVAL];
   logic [VAL_W-1:0]      start_ff [NVAL];
   logic [VAL_W-1:0]      start_in [NVAL];
   logic [VAL_W-1:0]      target_ff [NVAL];
   logic [VAL_W-1:0]      target_in [NVAL];
   logic [2:0]            mode_ff, mode_in;
   logic [FRAME_BITS-1:0] ticks_ff, ticks_in;
   logic [PROG_W-1:0]     progress_ff, progress_in;
   logic [PROG_W-1:0]     step_ff, step_in;
   logic                  active_ff, active_in;
   logic [WGT_W-1:0]      weight_ff, weight_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [VAL_W-1:0]      req_vals [NVAL];
   logic                  req_fire;
   logic [FRAME_BITS-1:0] frames_fix;
   logic                  recip_start;
   logic                  recip_done;
   logic [WGT_W-1:0]      recip_quot;
   logic signed [DIFF_W-1:0] mul_a;
   logic [WGT_W-1:0]      mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [PROG_W-IDX_SHIFT-1:0] sine_full;
   logic [SINE_BITS:0]    sine_idx;
   logic [WGT_W-1:0]      sine_w;
   logic [WGT_W-1:0]      lin_w;
   logic [PROG_W:0]       prog_sum;
   logic [VAL_W-1:0]      lerp_val;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign frames_fix = (req.frames == '0) ? FRAME_BITS'(1) : req.frames;

   assign req_vals[0] = req.pos_x;
   assign req_vals[1] = req.pos_y;
   assign req_vals[2] = req.pos_z;
   assign req_vals[3] = req.rot_x;
   assign req_vals[4] = req.rot_y;
   assign req_vals[5] = req.rot_z;
   assign req_vals[6] = req.zoom_value;

   // easing weights for the progress of this tick
   assign sine_full = progress_ff[PROG_W-1:IDX_SHIFT];
   assign sine_idx  = (sine_full > (PROG_W-IDX_SHIFT)'(SINE_DEPTH))
                    ? (SINE_BITS+1)'(SINE_DEPTH) : sine_full[SINE_BITS:0];
   assign sine_w    = SINE_TAB[sine_idx];
   assign lin_w     = (progress_ff > PROG_W'(ONE_FIX)) ? ONE_FIX : WGT_W'(progress_ff);
   assign prog_sum  = {1'b0, progress_ff} + {1'b0, step_ff};

   assign lerp_val  = start_ff[idx_ff] + prod[FRAC_BITS +: VAL_W];

   always_comb begin
      if (state_ff == ST_SQ) begin
         mul_a = DIFF_W'(weight_ff);
      end else begin
         mul_a = $signed({target_ff[idx_ff][VAL_W-1], target_ff[idx_ff]})
               - $signed({start_ff[idx_ff][VAL_W-1], start_ff[idx_ff]});
      end
      mul_b = weight_ff;
   end

   epi_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .start_i   (recip_start),
      .divisor_i (frames_fix),
      .done_o    (recip_done),
      .quot_o    (recip_quot)
   );

   epi_mul u_mul (
      .clock  (clock),
      .a_i    (mul_a),
      .b_i    (mul_b),
      .prod_o (prod)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      current_in   = current_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      mode_in      = mode_ff;
      ticks_in     = ticks_ff;
      progress_in  = progress_ff;
      step_in      = step_ff;
      active_in    = active_ff;
      weight_in    = weight_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      recip_start  = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DONE;
               case (req.kind)
                  KIND_TICK: begin
                     if (active_ff) begin
                        progress_in = prog_sum[PROG_W] ? '1 : prog_sum[PROG_W-1:0];
                        if (ticks_ff != '0) begin
                           ticks_in = ticks_ff - FRAME_BITS'(1);
                        end
                        if (progress_ff > HALF_FIX) begin
                           if (mode_ff == MODE_LIN_SINE) begin
                              mode_in = MODE_SINE;
                           end else if (mode_ff == MODE_SINE_SQSW) begin
                              mode_in = MODE_SINE_SQ;
                           end
                        end
                        idx_in = '0;
                        if (ticks_ff <= FRAME_BITS'(1)) begin
                           // last tick lands exactly on the targets
                           current_in = target_ff;
                           active_in  = 1'b0;
                        end else if (mode_ff == MODE_SINE_SQ) begin
                           weight_in = sine_w;
                           state_in  = ST_SQ;
                        end else if (mode_ff == MODE_SINE || mode_ff == MODE_SINE_SQSW) begin
                           weight_in = sine_w;
                           state_in  = ST_MUL;
                        end else begin
                           weight_in = lin_w;
                           state_in  = ST_MUL;
                        end
                     end
                  end
                  KIND_START: begin
                     for (int i = 0; i < NVAL; i++) begin
                        start_in[i]  = current_ff[i];
                        target_in[i] = req.group_mask[GROUP_OF[i]] ? req_vals[i]
                                                                   : current_ff[i];
                     end
                     mode_in     = req.ease_mode;
                     ticks_in    = frames_fix;
                     progress_in = '0;
                     active_in   = 1'b1;
                     recip_start = 1'b1;
                     state_in    = ST_DIV;
                  end
                  KIND_SET: begin
                     for (int i = 0; i < NVAL; i++) begin
                        if (req.group_mask[GROUP_OF[i]]) begin
                           current_in[i] = req_vals[i];
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (recip_done) begin
               step_in  = PROG_W'(recip_quot);
               state_in = ST_DONE;
            end
         end
         ST_SQ: begin
            state_in = ST_SQW;
         end
         ST_SQW: begin
            weight_in = prod[FRAC_BITS +: WGT_W];
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            current_in[idx_ff] = lerp_val;
            if (idx_ff == IDX_W'(NVAL - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.out_pos_x = current_ff[0];
               rsp_in.out_pos_y = current_ff[1];
               rsp_in.out_pos_z = current_ff[2];
               rsp_in.out_rot_x = current_ff[3];
               rsp_in.out_rot_y = current_ff[4];
               rsp_in.out_rot_z = current_ff[5];
               rsp_in.out_zoom  = current_ff[6];
               rsp_in.busy_res  = active_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         mode_ff      <= MODE_LINEAR;
         ticks_ff     <= '0;
         progress_ff  <= '0;
         step_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NVAL; i++) begin
            current_ff[i] <= '0;
            start_ff[i]   <= '0;
            target_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         mode_ff      <= mode_in;
         ticks_ff     <= ticks_in;
         progress_ff  <= progress_in;
         step_ff      <= step_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         current_ff   <= current_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
      end
      weight_ff <= weight_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/epi_checker.sv */
// ----------------------------------------------------------------------------
// epi_checker
// Port-level checks of the pose interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module epi_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire epi_pkg::rsp_type rsp
);
   import epi_pkg::*;

   // reset leaves no result pending and the block ready
   `ASSERT_NXT_NR(a_reset_idle, clock, reset, !rsp_valid && !req_stall)

   // a stalled result transaction holds
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

   // an accepted transaction keeps the block busy for at least the next cycle
   `ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a new result only shows up at the end of work on an item
   `ASSERT_IMP(a_rsp_from_work, clock, reset, rsp_valid && !$past(rsp_valid), $past(req_stall))

endmodule

bind eased_pose_interpolator epi_checker u_epi_checker (.*);

`default_nettype wire
